// ===== design/arm26_integer_execute_core_assert.svh =====
// Assertion macros used by the execute core back end.
`ifndef ARM26_INTEGER_EXECUTE_CORE_ASSERT_SVH
`define ARM26_INTEGER_EXECUTE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ARM26_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ARM26_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ARM26_ASSERT_IMPL(lbl, a, b)
`define ARM26_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== design/arm26_pkg.sv =====
// Shared types and codes for the ARMv2 26-bit integer execute core.
package arm26_pkg;
  localparam logic [2:0] ST_EXEC  = 3'd0;
  localparam logic [2:0] ST_CFAIL = 3'd1;
  localparam logic [2:0] ST_SWI   = 3'd2;
  localparam logic [2:0] ST_UNDEF = 3'd3;
  localparam logic [2:0] ST_TRAP  = 3'd4;

  localparam logic [2:0] CL_MUL  = 3'd0;
  localparam logic [2:0] CL_DP   = 3'd1;
  localparam logic [2:0] CL_UND  = 3'd2;
  localparam logic [2:0] CL_TRAP = 3'd3;
  localparam logic [2:0] CL_BR   = 3'd4;
  localparam logic [2:0] CL_SWI  = 3'd5;

  typedef struct packed {
    logic [2:0]  cls;
    logic [31:0] insn;
  } entry_t;
endpackage

// ===== design/arm26_front.sv =====
// Front end: accepts instruction words and tags each with its decode class.
module arm26_front (
  input  logic                 in_valid,
  input  logic [31:0]          in_instruction,
  output arm26_pkg::entry_t    push_entry,
  output logic                 push
);
  logic [2:0] cls;

  always_comb begin
    if ((in_instruction & 32'h0fc000f0) == 32'h00000090) begin
      cls = arm26_pkg::CL_MUL;
    end else if (in_instruction[27:26] == 2'b00) begin
      cls = arm26_pkg::CL_DP;
    end else if (in_instruction[27:26] == 2'b01) begin
      cls = (in_instruction[25] && in_instruction[4]) ? arm26_pkg::CL_UND : arm26_pkg::CL_TRAP;
    end else if (in_instruction[27:25] == 3'b100) begin
      cls = arm26_pkg::CL_TRAP;
    end else if (in_instruction[27:25] == 3'b101) begin
      cls = arm26_pkg::CL_BR;
    end else if (in_instruction[27:24] == 4'hf) begin
      cls = arm26_pkg::CL_SWI;
    end else begin
      cls = arm26_pkg::CL_UND;
    end
  end

  assign push = in_valid;
  assign push_entry = '{cls: cls, insn: in_instruction};
endmodule

// ===== design/arm26_queue.sv =====
// Two-entry queue between the decode front end and the execute back end.
module arm26_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  arm26_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output arm26_pkg::entry_t head
);
  arm26_pkg::entry_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_entry;
    end
  end
endmodule

// ===== design/arm26_back.sv =====
// Execute back end: register file, R15, shifter, ALU, multiplier and result register.
`include "arm26_integer_execute_core_assert.svh"
module arm26_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  arm26_pkg::entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [31:0]       out_next_r15,
  output logic              out_reg_written,
  output logic [3:0]        out_dest_index,
  output logic [31:0]       out_dest_value
);
  logic [31:0] regs_r [15];
  logic [31:0] r15_r, r15_nxt, swi_r;
  logic [31:0] r15_out_r;
  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic        wr_r, wr_nxt;
  logic [3:0]  di_r, di_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic        fire;

  function automatic logic [31:0] adv(input logic [31:0] r, input logic [3:0] k);
    adv = {r[31:26], r[25:2] + 24'(k[3:2]), r[1:0]};
  endfunction

  function automatic logic [32:0] shift_by(input logic [1:0] ty, input logic [31:0] x,
                                           input logic [7:0] s);
    logic [32:0] t;
    logic [31:0] rr;
    logic [5:0]  sc;
    t  = '0;
    rr = '0;
    sc = (s > 8'd32) ? 6'd32 : s[5:0];
    case (ty)
      2'd0: begin
        if (s <= 8'd32) begin
          t = {1'b0, x} << sc;
          shift_by = {t[32], t[31:0]};
        end else begin
          shift_by = '0;
        end
      end
      2'd1: begin
        if (s <= 8'd32) begin
          t = {x, 1'b0} >> sc;
          shift_by = {t[0], t[32:1]};
        end else begin
          shift_by = '0;
        end
      end
      2'd2: begin
        t = $unsigned($signed({x, 1'b0}) >>> sc);
        shift_by = {t[0], t[32:1]};
      end
      default: begin
        if (s[4:0] == 5'd0) begin
          shift_by = {x[31], x};
        end else begin
          rr = (x >> s[4:0]) | (x << (6'd32 - {1'b0, s[4:0]}));
          shift_by = {rr[31], rr};
        end
      end
    endcase
  endfunction

  function automatic logic cond_ok(input logic [3:0] c, input logic [31:0] f);
    logic n, z, cf, v;
    n = f[31]; z = f[30]; cf = f[29]; v = f[28];
    case (c)
      4'd0:  cond_ok = z;
      4'd1:  cond_ok = !z;
      4'd2:  cond_ok = cf;
      4'd3:  cond_ok = !cf;
      4'd4:  cond_ok = n;
      4'd5:  cond_ok = !n;
      4'd6:  cond_ok = v;
      4'd7:  cond_ok = !v;
      4'd8:  cond_ok = cf && !z;
      4'd9:  cond_ok = !cf || z;
      4'd10: cond_ok = n == v;
      4'd11: cond_ok = n != v;
      4'd12: cond_ok = !z && (n == v);
      4'd13: cond_ok = z || (n != v);
      4'd14: cond_ok = 1'b1;
      default: cond_ok = 1'b0;
    endcase
  endfunction

  logic [31:0] insn, pc, base, rm_v, rs_v, rn_v, ra_v, op2, res, rimm, nzcv, msk, prod;
  logic [32:0] sh, sum;
  logic [31:0] add_a, add_b;
  logic        cin, sc, c, v, add_ci, is_arith, user, regsh;
  logic [3:0]  op, rdn, rnn, off;
  logic [7:0]  samt;
  logic        swi_we, rf_we;
  logic [3:0]  rf_idx;

  assign fire  = q_nonempty && (!out_valid_r || !out_stall);
  assign q_pop = fire;

  always_comb begin
    insn  = q_head.insn;
    pc    = r15_r;
    base  = adv(pc, 4'd4);
    cin   = pc[29];
    user  = (pc[1:0] == 2'b00);
    regsh = !insn[25] && insn[4];
    off   = (regsh && (q_head.cls != arm26_pkg::CL_MUL)) ? 4'd12 : 4'd8;
    op    = insn[24:21];
    rdn   = insn[15:12];
    rnn   = insn[19:16];
    rm_v  = (insn[3:0] == 4'hf) ? adv(pc, off) : regs_r[insn[3:0]];
    rs_v  = (insn[11:8] == 4'hf) ? adv(pc, off) : regs_r[insn[11:8]];
    ra_v  = (insn[15:12] == 4'hf) ? adv(pc, 4'd8) : regs_r[insn[15:12]];
    rn_v  = (rnn == 4'hf) ? {6'd0, pc[25:2] + 24'(off[3:2]), 2'b00} : regs_r[rnn];
    rimm  = '0;
    sh    = '0;
    samt  = '0;
    op2   = rm_v;
    sc    = cin;
    if (insn[25]) begin
      rimm = {24'd0, insn[7:0]};
      rimm = (rimm >> {insn[11:8], 1'b0}) | (rimm << (6'd32 - {1'b0, insn[11:8], 1'b0}));
      op2  = rimm;
      sc   = (insn[11:8] == 4'd0) ? cin : rimm[31];
    end else if (insn[4]) begin
      samt = rs_v[7:0];
      sh   = shift_by(insn[6:5], rm_v, samt);
      if (samt != 8'd0) begin
        op2 = sh[31:0];
        sc  = sh[32];
      end
    end else if (insn[11:7] != 5'd0) begin
      samt = {3'd0, insn[11:7]};
      sh   = shift_by(insn[6:5], rm_v, samt);
      op2  = sh[31:0];
      sc   = sh[32];
    end else begin
      case (insn[6:5])
        2'd0: begin
          op2 = rm_v;
          sc  = cin;
        end
        2'd3: begin
          op2 = {cin, rm_v[31:1]};
          sc  = rm_v[0];
        end
        default: begin
          sh  = shift_by(insn[6:5], rm_v, 8'd32);
          op2 = sh[31:0];
          sc  = sh[32];
        end
      endcase
    end

    is_arith = 1'b1;
    add_a = rn_v;
    add_b = op2;
    add_ci = 1'b0;
    case (op)
      4'd2, 4'd10: begin add_b = ~op2; add_ci = 1'b1; end
      4'd3:        begin add_a = op2; add_b = ~rn_v; add_ci = 1'b1; end
      4'd5:        begin add_ci = cin; end
      4'd6:        begin add_b = ~op2; add_ci = cin; end
      4'd7:        begin add_a = op2; add_b = ~rn_v; add_ci = cin; end
      4'd4, 4'd11: begin add_ci = 1'b0; end
      default:     begin is_arith = 1'b0; end
    endcase
    sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};
    case (op)
      4'd0, 4'd8:  res = rn_v & op2;
      4'd1, 4'd9:  res = rn_v ^ op2;
      4'd12:       res = rn_v | op2;
      4'd13:       res = op2;
      4'd14:       res = rn_v & ~op2;
      4'd15:       res = ~op2;
      default:     res = sum[31:0];
    endcase
    c = is_arith ? sum[32] : sc;
    v = is_arith ? (~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31])) : pc[28];
    nzcv = {res[31], (res == 32'd0), c, v, 28'd0};

    prod = rm_v * rs_v;
    if (insn[21]) begin
      prod = prod + ra_v;
    end

    status_nxt = arm26_pkg::ST_EXEC;
    r15_nxt = pc;
    wr_nxt = 1'b0;
    di_nxt = '0;
    dv_nxt = '0;
    swi_we = 1'b0;
    msk = '0;
    if (!cond_ok(insn[31:28], pc)) begin
      status_nxt = arm26_pkg::ST_CFAIL;
      r15_nxt = base;
    end else begin
      case (q_head.cls)
        arm26_pkg::CL_MUL: begin
          r15_nxt = base;
          if (insn[20]) begin
            r15_nxt[31] = prod[31];
            r15_nxt[30] = (prod == 32'd0);
          end
          if (rnn != 4'hf) begin
            wr_nxt = 1'b1; di_nxt = rnn; dv_nxt = prod;
          end
        end
        arm26_pkg::CL_DP: begin
          if (op[3:2] == 2'b10) begin
            if (!insn[20]) begin
              r15_nxt = base;
            end else if (rdn == 4'hf) begin
              msk = user ? 32'hf0000000 : 32'hfc000003;
              r15_nxt = (base & ~msk) | (res & msk);
            end else begin
              r15_nxt = {nzcv[31:28], base[27:0]};
            end
          end else if (rdn == 4'hf) begin
            msk = insn[20] ? (user ? 32'hf3fffffc : 32'hffffffff) : 32'h03fffffc;
            r15_nxt = (pc & ~msk) | (res & msk);
          end else begin
            wr_nxt = 1'b1; di_nxt = rdn; dv_nxt = res;
            r15_nxt = insn[20] ? {nzcv[31:28], base[27:0]} : base;
          end
        end
        arm26_pkg::CL_TRAP: status_nxt = arm26_pkg::ST_TRAP;
        arm26_pkg::CL_BR: begin
          r15_nxt = {pc[31:26], pc[25:2] + 24'd2 + insn[23:0], pc[1:0]};
          if (insn[24]) begin
            wr_nxt = 1'b1; di_nxt = 4'd14; dv_nxt = base;
          end
        end
        arm26_pkg::CL_SWI: begin
          status_nxt = arm26_pkg::ST_SWI;
          r15_nxt = base;
          swi_we = 1'b1;
        end
        default: status_nxt = arm26_pkg::ST_UNDEF;
      endcase
    end
    rf_we  = fire && wr_nxt;
    rf_idx = di_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r15_r       <= '0;
      swi_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 15; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (fire) begin
        r15_r <= r15_nxt;
      end
      if (fire && swi_we) begin
        swi_r <= insn;
      end
      if (rf_we) begin
        regs_r[rf_idx] <= dv_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fire) begin
      status_r <= status_nxt;
      wr_r     <= wr_nxt;
      di_r     <= di_nxt;
      dv_r     <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r15_out_r <= r15_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_next_r15    = r15_out_r;
  assign out_reg_written = wr_r;
  assign out_dest_index  = di_r;
  assign out_dest_value  = dv_r;

  `ARM26_ASSERT_IMPL(a_no_r15_wr, out_valid_r && wr_r, di_r != 4'hf)
  `ARM26_ASSERT_IMPL(a_wr_only_exec, out_valid_r && wr_r, status_r == arm26_pkg::ST_EXEC)
  `ARM26_ASSERT_NEXT(a_hold, out_valid_r && out_stall, out_valid_r && $stable(dv_r))
  `ARM26_ASSERT_NEXT(a_swi_latch, fire && swi_we, swi_r == $past(insn))
endmodule

// ===== design/arm26_integer_execute_core.sv =====
// Top level of the ARMv2 26-bit integer execute core.
// One instruction enters per cycle unless the input stalls; it goes into the decode queue,
// then executes from the queue head into the result register. With no output stalls the
// core retires one instruction every cycle; the execute stage holds the register file and
// combined R15. While the output is stalled the two-entry decode queue and the result
// register hold up to three instructions before the input stalls. Data processing,
// branches, multiply and SWI execute; memory transfers return a trap status and change nothing.
module arm26_integer_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_next_r15,
  output logic        out_reg_written,
  output logic [3:0]  out_dest_index,
  output logic [31:0] out_dest_value
);
  arm26_pkg::entry_t push_entry, head;
  logic push, full, pop, nonempty;

  arm26_front u_front (
    .in_valid(in_valid), .in_instruction(in_instruction),
    .push_entry(push_entry), .push(push)
  );

  arm26_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_entry(push_entry), .full(full),
    .pop(pop), .nonempty(nonempty), .head(head)
  );

  arm26_back u_back (
    .clk(clk), .rst_n(rst_n), .q_nonempty(nonempty), .q_head(head), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_next_r15(out_next_r15), .out_reg_written(out_reg_written),
    .out_dest_index(out_dest_index), .out_dest_value(out_dest_value)
  );

  assign in_stall = full;
endmodule

// ===== tb/arm26_integer_execute_core_checker.sv =====
// Checker for the execute core: predicts each instruction's result and compares it.
module arm26_integer_execute_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_instruction,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_next_r15,
  input  logic        out_reg_written,
  input  logic [3:0]  out_dest_index,
  input  logic [31:0] out_dest_value,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] PC_MASK = 32'h03fffffc;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_r15;
    logic        reg_written;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
  } retire_t;

  logic [31:0] gpr [15];
  logic [31:0] r15;
  logic [31:0] swi_word;
  retire_t     retire_q[$];

  function automatic logic [31:0] pc_add(logic [31:0] r, logic [31:0] k);
    return (r & ~PC_MASK) | ((r + k) & PC_MASK);
  endfunction

  function automatic logic [31:0] reg_read(logic [3:0] i, logic [31:0] off);
    return (i == 4'd15) ? pc_add(r15, off) : gpr[i];
  endfunction

  function automatic logic cond_pass(logic [3:0] cc, logic [31:0] f);
    logic n, z, c, v;
    n = f[31]; z = f[30]; c = f[29]; v = f[28];
    case (cc)
      4'd0: return z;
      4'd1: return !z;
      4'd2: return c;
      4'd3: return !c;
      4'd4: return n;
      4'd5: return !n;
      4'd6: return v;
      4'd7: return !v;
      4'd8: return c && !z;
      4'd9: return !c || z;
      4'd10: return n == v;
      4'd11: return n != v;
      4'd12: return !z && (n == v);
      4'd13: return z || (n != v);
      4'd14: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] barrel(logic [1:0] kind, logic [31:0] x, logic [31:0] s,
                                         output logic co);
    logic [4:0] r;
    case (kind)
      2'd0: begin
        if (s < 32) begin
          co = x[32 - s];
          return x << s;
        end
        co = (s == 32) ? x[0] : 1'b0;
        return 32'd0;
      end
      2'd1: begin
        if (s < 32) begin
          co = x[s - 1];
          return x >> s;
        end
        co = (s == 32) ? x[31] : 1'b0;
        return 32'd0;
      end
      2'd2: begin
        if (s < 32) begin
          co = x[s - 1];
          return $unsigned($signed(x) >>> s);
        end
        co = x[31];
        return {32{x[31]}};
      end
      default: begin
        r = s[4:0];
        if (r == 0) begin
          co = x[31];
          return x;
        end
        co = x[r - 1];
        return (x >> r) | (x << (6'd32 - r));
      end
    endcase
  endfunction

  function automatic logic [31:0] shifter_operand(logic [31:0] insn, logic cin, output logic co);
    logic [31:0] imm, rm, s;
    logic [4:0]  rot;
    if (insn[25]) begin
      imm = {24'd0, insn[7:0]};
      rot = {insn[11:8], 1'b0};
      co = cin;
      if (rot == 0) return imm;
      imm = (imm >> rot) | (imm << (6'd32 - rot));
      co = imm[31];
      return imm;
    end
    if (insn[4]) begin
      rm = reg_read(insn[3:0], 12);
      s = reg_read(insn[11:8], 12) & 32'hff;
      co = cin;
      if (s == 0) return rm;
      return barrel(insn[6:5], rm, s, co);
    end
    rm = reg_read(insn[3:0], 8);
    s = {27'd0, insn[11:7]};
    if (s != 0) return barrel(insn[6:5], rm, s, co);
    case (insn[6:5])
      2'd0: begin
        co = cin;
        return rm;
      end
      2'd1: return barrel(2'd1, rm, 32, co);
      2'd2: return barrel(2'd2, rm, 32, co);
      default: begin
        co = rm[0];
        return {cin, rm[31:1]};
      end
    endcase
  endfunction

  function automatic logic [31:0] add_with_carry(logic [31:0] a, logic [31:0] b, logic cin,
                                                 output logic c, output logic v);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    c = sum[32];
    v = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
    return sum[31:0];
  endfunction

  task automatic execute_insn(logic [31:0] insn);
    retire_t     e;
    logic [31:0] pc, nxt, res, rn, op2, base, m, off, nzcv;
    logic        cin, sc, c, v, user, sbit;
    logic [3:0]  op, rd, rnn;
    pc = r15;
    nxt = pc;
    cin = pc[29];
    user = (pc[1:0] == 2'd0);
    e = '0;
    e.status = arm26_pkg::ST_EXEC;
    if (!cond_pass(insn[31:28], pc)) begin
      e.status = arm26_pkg::ST_CFAIL;
      nxt = pc_add(pc, 4);
    end else if ((insn & 32'h0fc000f0) == 32'h00000090) begin
      res = reg_read(insn[3:0], 8) * reg_read(insn[11:8], 8);
      if (insn[21]) res = res + reg_read(insn[15:12], 8);
      nxt = pc_add(pc, 4);
      if (insn[20]) nxt = {res[31], res == 0, nxt[29:0]};
      if (insn[19:16] != 4'd15) begin
        gpr[insn[19:16]] = res;
        e.reg_written = 1'b1;
        e.dest_index = insn[19:16];
        e.dest_value = res;
      end
    end else if (insn[27:26] == 2'b00) begin
      op = insn[24:21];
      sbit = insn[20];
      rd = insn[15:12];
      rnn = insn[19:16];
      c = cin;
      v = pc[28];
      op2 = shifter_operand(insn, cin, sc);
      if (rnn == 4'd15)
        rn = (pc + ((!insn[25] && insn[4]) ? 32'd12 : 32'd8)) & PC_MASK;
      else
        rn = gpr[rnn];
      case (op)
        4'd0, 4'd8: begin res = rn & op2; c = sc; end
        4'd1, 4'd9: begin res = rn ^ op2; c = sc; end
        4'd2, 4'd10: res = add_with_carry(rn, ~op2, 1'b1, c, v);
        4'd3: res = add_with_carry(op2, ~rn, 1'b1, c, v);
        4'd4, 4'd11: res = add_with_carry(rn, op2, 1'b0, c, v);
        4'd5: res = add_with_carry(rn, op2, cin, c, v);
        4'd6: res = add_with_carry(rn, ~op2, cin, c, v);
        4'd7: res = add_with_carry(op2, ~rn, cin, c, v);
        4'd12: begin res = rn | op2; c = sc; end
        4'd13: begin res = op2; c = sc; end
        4'd14: begin res = rn & ~op2; c = sc; end
        default: begin res = ~op2; c = sc; end
      endcase
      nzcv = {res[31], res == 0, c, v, 28'd0};
      base = pc_add(pc, 4);
      if (op >= 4'd8 && op <= 4'd11) begin
        if (!sbit) begin
          nxt = base;
        end else if (rd == 4'd15) begin
          m = user ? 32'hf0000000 : 32'hfc000003;
          nxt = (base & ~m) | (res & m);
        end else begin
          nxt = (base & 32'h0fffffff) | nzcv;
        end
      end else if (rd == 4'd15) begin
        m = sbit ? (user ? 32'hf3fffffc : 32'hffffffff) : PC_MASK;
        nxt = (pc & ~m) | (res & m);
      end else begin
        gpr[rd] = res;
        e.reg_written = 1'b1;
        e.dest_index = rd;
        e.dest_value = res;
        nxt = sbit ? ((base & 32'h0fffffff) | nzcv) : base;
      end
    end else if (insn[27:26] == 2'b01) begin
      e.status = (insn[25] && insn[4]) ? arm26_pkg::ST_UNDEF : arm26_pkg::ST_TRAP;
    end else if (insn[27:25] == 3'b100) begin
      e.status = arm26_pkg::ST_TRAP;
    end else if (insn[27:25] == 3'b101) begin
      off = {{6{insn[23]}}, insn[23:0], 2'b00};
      if (insn[24]) begin
        gpr[14] = pc_add(pc, 4);
        e.reg_written = 1'b1;
        e.dest_index = 4'd14;
        e.dest_value = gpr[14];
      end
      nxt = (pc & ~PC_MASK) | ((pc + 8 + off) & PC_MASK);
    end else if (insn[27:24] == 4'hf) begin
      e.status = arm26_pkg::ST_SWI;
      swi_word = insn;
      nxt = pc_add(pc, 4);
    end else begin
      e.status = arm26_pkg::ST_UNDEF;
    end
    r15 = nxt;
    e.next_r15 = nxt;
    retire_q.push_back(e);
  endtask

  always @(posedge clk) begin
    retire_t e;
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = '0;
      r15 = '0;
      swi_word = '0;
      retire_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (retire_q.size() == 0) begin
          $error("result with no instruction outstanding");
          fail_count++;
        end else begin
          e = retire_q.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status);
            fail_count++;
          end
          if (out_next_r15 !== e.next_r15) begin
            $error("next_r15: expected %h actual %h", e.next_r15, out_next_r15);
            fail_count++;
          end
          if (out_reg_written !== e.reg_written) begin
            $error("reg_written: expected %0d actual %0d", e.reg_written, out_reg_written);
            fail_count++;
          end
          if (out_dest_index !== e.dest_index) begin
            $error("dest_index: expected %0d actual %0d", e.dest_index, out_dest_index);
            fail_count++;
          end
          if (out_dest_value !== e.dest_value) begin
            $error("dest_value: expected %h actual %h", e.dest_value, out_dest_value);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) execute_insn(in_instruction);
    end
    pending_count = retire_q.size();
  end
endmodule

// ===== tb/tb_arm26_integer_execute_core.sv =====
// Top of the execute core testbench: clock, reset, instruction stimulus and verdict.
module tb_arm26_integer_execute_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_instruction = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  out_status;
  logic [31:0] out_next_r15;
  logic        out_reg_written;
  logic [3:0]  out_dest_index;
  logic [31:0] out_dest_value;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_off = 0;

  always #6 clk = ~clk;

  arm26_integer_execute_core uut (.*);

  arm26_integer_execute_core_checker chk (.*);

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_stall <= hold_off;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_insn(logic [31:0] insn);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_instruction <= insn;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_insn();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(9))
      0, 1, 2, 3: w[27:26] = 2'b00;
      4: begin
        w[27:22] = 6'd0;
        w[7:4] = 4'b1001;
      end
      5: w[27:25] = 3'b101;
      6: w[27:24] = 4'hf;
      default: ;
    endcase
    if ($urandom_range(3) != 0) w[31:28] = 4'he;
    if ($urandom_range(3) == 0) w[3:0] = 4'hf;
    if ($urandom_range(3) == 0) w[19:16] = 4'hf;
    if ($urandom_range(4) == 0) w[15:12] = 4'hf;
    return w;
  endfunction

  initial begin
    logic [31:0] directed [$];
    directed = '{32'he3a00000, 32'he3e01000, 32'he3b02102, 32'he0912001, 32'he2533001,
                 32'he1a04f61, 32'he1a05021, 32'he1a06041, 32'he1b07061, 32'he1a08112,
                 32'he0090192, 32'he0390f91, 32'he28ff000, 32'he33ff003, 32'he1100000,
                 32'heb000001, 32'heafffffe, 32'hef123456, 32'he5900000, 32'he7900010,
                 32'he8900003, 32'hee000000, 32'hf3a00001, 32'h03a00001, 32'he08f000f};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send_insn(directed[i]);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 36 : 67) : 0;
      stall_pct = (phase == 2) ? 67 : ((phase == 3) ? 36 : 0);
      for (int k = 0; k < 400; k++) send_insn(random_insn());
      in_valid <= 0;
      wait_drained();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1;
    fork
      begin
        repeat (40) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 25; k++) send_insn(random_insn());
    join
    in_valid <= 0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("arm26_integer_execute_core regression: pass");
    else
      $display("arm26_integer_execute_core regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("arm26_integer_execute_core regression: fail");
    $finish;
  end
endmodule
